@@ src/rtsl_pkg.sv @@
// Shared types and constants for the ready-to-send list.
package rtsl_pkg;

	localparam int unsigned DEV_W   = 6;
	localparam int unsigned FLAGS_W = 32;
	localparam int unsigned CHG_W   = 2;

	localparam logic [FLAGS_W-1:0] READY_MASK  = 32'h7FFF_FFFF;
	localparam logic [FLAGS_W-1:0] COMPUTE_BIT = 32'h8000_0000;

	typedef enum logic {
		ACT_UPDATE = 1'b0,
		ACT_POP    = 1'b1
	} act_t;

	typedef enum logic [CHG_W-1:0] {
		CHG_NONE   = 2'd0,
		CHG_APPEND = 2'd1,
		CHG_REMOVE = 2'd2
	} chg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPEND_LINK,
		ST_UNLINK,
		ST_POP
	} state_t;

endpackage

@@ src/rtsl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rtsl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/ready_to_send_list.sv @@
// Top level of the ready-to-send list: sequencer, head/tail, membership and link RAMs.
//
// Usage
//   Command channel: drive action, device and ready_flags and raise start; the
//   word is taken at a rising edge where start is high and busy is low.
//   action = update: bits 30..0 of ready_flags nonzero appends an unlisted
//   device at the tail, all zero unlinks a listed device from any position;
//   bit 31 is echoed on recheck_compute. action = pop: remove the head and
//   report it on popped_device with popped_valid, or popped_valid low if empty.
//   Result channel: exactly one result word per command, shown for one cycle
//   with done high. The receiver cannot stall; it must take the word then.
//   Result timing: the result appears in the cycle after accept for no-change
//   updates, appends to an empty list and empty pops. Appends behind an existing
//   tail, unlinks and pops first pass through ST_APPEND_LINK, ST_UNLINK or ST_POP
//   while busy is high, and the result follows that state; the extra state is
//   the registered read of the next and prev link RAMs, or the second write to
//   the next link RAM on append.
//   Reset: head and tail go to the null code, every membership bit clears.
//   The link RAMs need no clearing; an entry is read only after its device
//   was appended.
module ready_to_send_list #(
	parameter int unsigned NUM_DEVICES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [rtsl_pkg::DEV_W-1:0]    device,
	input  logic [rtsl_pkg::FLAGS_W-1:0]  ready_flags,
	output logic                          done,
	output logic                          popped_valid,
	output logic [rtsl_pkg::DEV_W-1:0]    popped_device,
	output logic [rtsl_pkg::CHG_W-1:0]    list_change,
	output logic                          recheck_compute,
	output logic                          list_nonempty
);

	import rtsl_pkg::*;

	// Only devices reachable through the device port can ever be listed.
	localparam int unsigned DEV_SPAN = 1 << DEV_W;
	localparam int unsigned DEV_N    = (NUM_DEVICES < DEV_SPAN) ? NUM_DEVICES : DEV_SPAN;
	localparam int unsigned AW       = $clog2(DEV_N);
	// Link width holds every device index plus the null code NUM_DEVICES.
	localparam int unsigned LW       = $clog2(NUM_DEVICES + 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(NUM_DEVICES);

	state_t state_q, state_d;

	logic [LW-1:0]    head_q, tail_q, head_d, tail_d;
	logic [DEV_N-1:0] on_list_q;

	// Command word held while the sequencer works on it.
	logic [DEV_W-1:0] dev_q;
	logic [LW-1:0]    aux_q;
	logic             rtc_q;

	// Result word registers.
	logic             done_q;
	logic             pv_q;
	logic [DEV_W-1:0] pd_q;
	chg_t             chg_q;
	logic             rtc_out_q;
	logic             ne_q;

	// Link RAM ports.
	logic          nx_we, pv_we;
	logic [AW-1:0] nx_wa, pv_wa, rd_addr;
	logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;

	// Sequencer decisions.
	logic          accept;
	logic          emit;
	logic          set_on, clr_on;
	logic [AW-1:0] on_idx;
	logic          r_pv;
	logic [DEV_W-1:0] r_pd;
	chg_t          r_chg;
	logic          r_rtc;

	logic          dev_ok, ready, listed;
	logic [LW-1:0] dev_link, held_link, p_link, n_link;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign dev_ok    = (32'(device) < 32'(NUM_DEVICES));
	assign ready     = ((ready_flags & READY_MASK) != '0);
	assign listed    = on_list_q[AW'(device)];
	assign dev_link  = LW'(device);
	assign held_link = LW'(dev_q);

	// Sanitize link reads: anything that is not a device counts as null.
	assign p_link = (pv_rd < NULL_LINK) ? pv_rd : NULL_LINK;
	assign n_link = (nx_rd < NULL_LINK) ? nx_rd : NULL_LINK;

	rtsl_ram #(
		.WIDTH(LW),
		.DEPTH(DEV_N)
	) u_next_ram (
		.clk  (clk),
		.we   (nx_we),
		.waddr(nx_wa),
		.wdata(nx_wd),
		.raddr(rd_addr),
		.rdata(nx_rd)
	);

	rtsl_ram #(
		.WIDTH(LW),
		.DEPTH(DEV_N)
	) u_prev_ram (
		.clk  (clk),
		.we   (pv_we),
		.waddr(pv_wa),
		.wdata(pv_wd),
		.raddr(rd_addr),
		.rdata(pv_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		tail_d  = tail_q;
		nx_we   = 1'b0;
		nx_wa   = AW'(dev_q);
		nx_wd   = NULL_LINK;
		pv_we   = 1'b0;
		pv_wa   = AW'(dev_q);
		pv_wd   = NULL_LINK;
		rd_addr = AW'(dev_q);
		set_on  = 1'b0;
		clr_on  = 1'b0;
		on_idx  = AW'(dev_q);
		emit    = 1'b0;
		r_pv    = 1'b0;
		r_pd    = '0;
		r_chg   = CHG_NONE;
		r_rtc   = rtc_q;

		case (state_q)
			ST_IDLE: begin
				// Read ahead: the head's successor for a pop, the device's links otherwise.
				rd_addr = (action == ACT_POP) ? AW'(head_q) : AW'(device);
				if (accept) begin
					if (action == ACT_POP) begin
						r_rtc = 1'b0;
						if (head_q < NULL_LINK) begin
							state_d = ST_POP;
						end else begin
							emit = 1'b1;
						end
					end else begin
						r_rtc = ((ready_flags & COMPUTE_BIT) != '0);
						if (dev_ok && ready && !listed) begin
							// Append: write the new entry now, link the old tail next cycle.
							nx_we  = 1'b1;
							nx_wa  = AW'(device);
							nx_wd  = NULL_LINK;
							pv_we  = 1'b1;
							pv_wa  = AW'(device);
							pv_wd  = tail_q;
							tail_d = dev_link;
							set_on = 1'b1;
							on_idx = AW'(device);
							if (tail_q < NULL_LINK) begin
								state_d = ST_APPEND_LINK;
							end else begin
								head_d = dev_link;
								emit   = 1'b1;
								r_chg  = CHG_APPEND;
							end
						end else if (dev_ok && !ready && listed) begin
							state_d = ST_UNLINK;
						end else begin
							emit = 1'b1;
						end
					end
				end
			end
			ST_APPEND_LINK: begin
				nx_we   = 1'b1;
				nx_wa   = AW'(aux_q);
				nx_wd   = held_link;
				emit    = 1'b1;
				r_chg   = CHG_APPEND;
				state_d = ST_IDLE;
			end
			ST_UNLINK: begin
				if (head_q == held_link) begin
					head_d = n_link;
				end else if (p_link < NULL_LINK) begin
					nx_we = 1'b1;
					nx_wa = AW'(p_link);
					nx_wd = n_link;
				end
				if (tail_q == held_link) begin
					tail_d = p_link;
				end else if (n_link < NULL_LINK) begin
					pv_we = 1'b1;
					pv_wa = AW'(n_link);
					pv_wd = p_link;
				end
				clr_on  = 1'b1;
				emit    = 1'b1;
				r_chg   = CHG_REMOVE;
				state_d = ST_IDLE;
			end
			ST_POP: begin
				if (n_link < NULL_LINK) begin
					pv_we = 1'b1;
					pv_wa = AW'(n_link);
					pv_wd = NULL_LINK;
				end else begin
					tail_d = NULL_LINK;
				end
				head_d  = n_link;
				clr_on  = 1'b1;
				on_idx  = AW'(head_q);
				emit    = 1'b1;
				r_pv    = 1'b1;
				r_pd    = DEV_W'(head_q);
				r_rtc   = 1'b0;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// List control state: head, tail, membership and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= NULL_LINK;
			tail_q    <= NULL_LINK;
			on_list_q <= '0;
			done_q    <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (set_on) begin
				on_list_q[on_idx] <= 1'b1;
			end
			if (clr_on) begin
				on_list_q[on_idx] <= 1'b0;
			end
			done_q <= emit;
		end
	end

	// Hold the command word and the result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			dev_q <= device;
			aux_q <= tail_q;
			rtc_q <= ((ready_flags & COMPUTE_BIT) != '0);
		end
		if (emit) begin
			pv_q      <= r_pv;
			pd_q      <= r_pd;
			chg_q     <= r_chg;
			rtc_out_q <= r_rtc;
			ne_q      <= (head_d < NULL_LINK);
		end
	end

	assign done            = done_q;
	assign popped_valid    = pv_q;
	assign popped_device   = pd_q;
	assign list_change     = chg_q;
	assign recheck_compute = rtc_out_q;
	assign list_nonempty   = ne_q;

`ifndef SYNTH
	// Head and tail are null together.
	a_head_tail_null: assert property (@(posedge clk) disable iff (!arst_n)
		((head_q == NULL_LINK) == (tail_q == NULL_LINK)))
		else $error("head and tail disagree on emptiness");

	// Membership bits are all clear exactly when the list is empty.
	a_members_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((on_list_q == '0) == (head_q == NULL_LINK)))
		else $error("membership bits disagree with head");

	// Every busy state is left for idle straight away; the sequencer never stays busy.
	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("sequencer stuck busy");

	// A pop result never reports a list change or a compute recheck.
	a_pop_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(done && popped_valid) |-> (list_change == CHG_NONE && !recheck_compute))
		else $error("pop result carries update fields");
`endif

endmodule

@@ bench/ready_to_send_list_test.sv @@
// Self-checking bench for the ready-to-send list: queued commands, live list predictor, result check.
module ready_to_send_list_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rtsl_pkg::*;

	localparam int unsigned NDEV        = 64;
	localparam logic [6:0]  NIL         = 7'd64;
	localparam int unsigned PHASE_ITEMS = 232;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_WAIT  = 8;

	// One command word as the driver presents it, plus the sender gap rate of its phase.
	typedef struct {
		act_t            act;
		logic [DEV_W-1:0]   dev;
		logic [FLAGS_W-1:0] flags;
		int unsigned     gap_pct;
	} list_cmd_t;

	// One result word as the block reports it.
	typedef struct {
		logic             pv;
		logic [DEV_W-1:0] pd;
		chg_t             chg;
		logic             rtc;
		logic             ne;
	} list_result_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 action = 1'b0;
	logic [DEV_W-1:0]     device = '0;
	logic [FLAGS_W-1:0]   ready_flags = '0;
	logic                 busy;
	logic                 done;
	logic                 popped_valid;
	logic [DEV_W-1:0]     popped_device;
	logic [CHG_W-1:0]     list_change;
	logic                 recheck_compute;
	logic                 list_nonempty;

	list_cmd_t    pending_cmds[$];
	list_result_t expected_words[$];
	list_cmd_t    cur_cmd;
	int unsigned  mismatch_cnt = 0;
	int unsigned  cycle_cnt = 0;

	// Shadow copy of the ready list: link arrays, membership bits, head and tail.
	logic [6:0] shadow_next[NDEV];
	logic [6:0] shadow_prev[NDEV];
	logic       shadow_on[NDEV];
	logic [6:0] shadow_head;
	logic [6:0] shadow_tail;

	ready_to_send_list #(
		.NUM_DEVICES(NDEV)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.device         (device),
		.ready_flags    (ready_flags),
		.done           (done),
		.popped_valid   (popped_valid),
		.popped_device  (popped_device),
		.list_change    (list_change),
		.recheck_compute(recheck_compute),
		.list_nonempty  (list_nonempty)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Apply one accepted command to the shadow list and return the word it must produce.
	function automatic list_result_t predict_list_step(list_cmd_t c);
		list_result_t r;
		logic [6:0]   d;
		logic [6:0]   h;
		logic [6:0]   p;
		logic [6:0]   n;
		r.pv  = 1'b0;
		r.pd  = '0;
		r.chg = CHG_NONE;
		r.rtc = 1'b0;
		d = {1'b0, c.dev};
		if (c.act == ACT_POP) begin
			// Pop on an empty list changes nothing and reports not-valid.
			if (shadow_head != NIL) begin
				h = shadow_head;
				n = shadow_next[h];
				if (n != NIL)
					shadow_prev[n] = NIL;
				else
					shadow_tail = NIL;
				shadow_head = n;
				shadow_on[h] = 1'b0;
				r.pv = 1'b1;
				r.pd = h[DEV_W-1:0];
			end
		end else begin
			r.rtc = c.flags[31];
			if ((c.flags & READY_MASK) != '0 && !shadow_on[d]) begin
				// Append behind the current tail, or start the list.
				shadow_prev[d] = shadow_tail;
				shadow_next[d] = NIL;
				if (shadow_tail != NIL)
					shadow_next[shadow_tail] = d;
				else
					shadow_head = d;
				shadow_tail = d;
				shadow_on[d] = 1'b1;
				r.chg = CHG_APPEND;
			end else if ((c.flags & READY_MASK) == '0 && shadow_on[d]) begin
				// Unlink from wherever it sits: head, tail, middle or sole entry.
				p = shadow_prev[d];
				n = shadow_next[d];
				if (shadow_head == d)
					shadow_head = n;
				else if (p != NIL)
					shadow_next[p] = n;
				if (shadow_tail == d)
					shadow_tail = p;
				else if (n != NIL)
					shadow_prev[n] = p;
				shadow_on[d] = 1'b0;
				r.chg = CHG_REMOVE;
			end
		end
		r.ne = (shadow_head != NIL);
		return r;
	endfunction

	task automatic queue_cmd(act_t a, logic [DEV_W-1:0] d, logic [FLAGS_W-1:0] f,
			int unsigned gap);
		list_cmd_t c;
		c.act     = a;
		c.dev     = d;
		c.flags   = f;
		c.gap_pct = gap;
		pending_cmds.push_back(c);
	endtask

	// Driver: record the accepted word, hold the current one while busy, else
	// present the next pending word or leave start low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_words.push_back(predict_list_step(cur_cmd));
			if (!(start && busy)) begin
				if (pending_cmds.size() != 0 &&
						$urandom_range(99) >= pending_cmds[0].gap_pct) begin
					cur_cmd = pending_cmds.pop_front();
					start       <= 1'b1;
					action      <= cur_cmd.act;
					device      <= cur_cmd.dev;
					ready_flags <= cur_cmd.flags;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done cycle carries one word; match it against the oldest expectation.
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				if (mismatch_cnt < 10)
					$display("unexpected result word: pv=%0b pd=%0d chg=%0d rtc=%0b ne=%0b",
						popped_valid, popped_device, list_change, recheck_compute,
						list_nonempty);
				mismatch_cnt++;
			end else begin
				e = expected_words.pop_front();
				if (popped_valid !== e.pv || popped_device !== e.pd ||
						list_change !== e.chg || recheck_compute !== e.rtc ||
						list_nonempty !== e.ne) begin
					if (mismatch_cnt < 10)
						$display("result mismatch: exp pv=%0b pd=%0d chg=%0d rtc=%0b ne=%0b",
							e.pv, e.pd, e.chg, e.rtc, e.ne,
							" | got pv=%0b pd=%0d chg=%0d rtc=%0b ne=%0b",
							popped_valid, popped_device, list_change,
							recheck_compute, list_nonempty);
					mismatch_cnt++;
				end
			end
		end
	end

	// Watchdog: end the run with a mismatch once the cycle limit is reached.
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned      gaps[4];
		int unsigned      r;
		logic [DEV_W-1:0] d;
		logic [31:0]      f;
		gaps[0] = 0;
		gaps[1] = 85;
		gaps[2] = 0;
		gaps[3] = 37;

		for (int i = 0; i < NDEV; i++) begin
			shadow_next[i] = NIL;
			shadow_prev[i] = NIL;
			shadow_on[i]   = 1'b0;
		end
		shadow_head = NIL;
		shadow_tail = NIL;

		// Directed opening: empty pops, idle updates, extremes of flags and device,
		// then unlink from the middle, the head, the tail and the sole entry.
		queue_cmd(ACT_POP,    6'd0,  32'h0000_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd0,  32'h0000_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd63, 32'h8000_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd63, 32'hFFFF_FFFF, 0);
		queue_cmd(ACT_UPDATE, 6'd63, 32'h8000_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd0,  32'h0000_0001, 0);
		queue_cmd(ACT_UPDATE, 6'd63, 32'h4000_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd5,  32'h7FFF_FFFF, 0);
		queue_cmd(ACT_UPDATE, 6'd1,  32'h8000_0001, 0);
		queue_cmd(ACT_UPDATE, 6'd5,  32'hFFFF_FFFF, 0);
		queue_cmd(ACT_UPDATE, 6'd5,  32'h0000_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd0,  32'h8000_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd1,  32'h0000_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd42, 32'h0000_0000, 0);
		queue_cmd(ACT_POP,    6'd63, 32'hFFFF_FFFF, 0);
		queue_cmd(ACT_POP,    6'd0,  32'h0000_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd21, 32'h0001_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd21, 32'h0000_0000, 0);
		queue_cmd(ACT_UPDATE, 6'd42, 32'h5555_5555, 0);
		queue_cmd(ACT_UPDATE, 6'd21, 32'hAAAA_AAAA, 0);
		queue_cmd(ACT_POP,    6'd0,  32'h0000_0000, 0);
		queue_cmd(ACT_POP,    6'd0,  32'h0000_0000, 0);
		queue_cmd(ACT_POP,    6'd0,  32'h0000_0000, 0);

		// Random phases: mostly updates on a small pool of devices so that
		// appends and unlinks hit listed entries, pops to drain, full range now and then.
		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(99);
				d = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(11));
				f = $urandom;
				if (r < 25) begin
					queue_cmd(ACT_POP, d, f, gaps[ph]);
				end else if (r < 70) begin
					if ($urandom_range(4) == 0)
						f = {f[31], 31'(32'h1 << $urandom_range(30))};
					if (f[30:0] == '0)
						f[0] = 1'b1;
					queue_cmd(ACT_UPDATE, d, f, gaps[ph]);
				end else begin
					queue_cmd(ACT_UPDATE, d, {f[31], 31'd0}, gaps[ph]);
				end
			end
		end

		// Hold reset while the clock runs, then release it once for the whole run.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every word taken, every result back, then let the pipe settle.
		while (pending_cmds.size() != 0 || start || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_cnt == 0 && expected_words.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ filelist.f @@
src/rtsl_pkg.sv
src/rtsl_ram.sv
src/ready_to_send_list.sv
bench/ready_to_send_list_test.sv
